// ===== hdl/bfk_pkg.sv =====
// shared types and constants of the keyed blowfish-style block cipher
package bfk_pkg;

	localparam int unsigned TABLE_WORDS = 1042;
	localparam int unsigned P_WORDS     = 18;
	localparam int unsigned SBOX_WORDS  = 1024;
	localparam int unsigned ROUNDS      = 16;

	localparam logic [10:0] TABLE_LAST  = 11'd1041;
	localparam logic [10:0] TABLE_END   = 11'd1042;
	localparam logic [10:0] FILL_LAST   = 11'd1040;
	localparam logic [10:0] P_BASE      = 11'd18;
	localparam logic [10:0] P_LAST      = 11'd17;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_SCHED = 2'd1,
		ACT_ENC   = 2'd2,
		ACT_DEC   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_ID_CODE    = 2'd0,
		CFG_KEY_LEVEL  = 2'd1,
		CFG_KEY_MODULO = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		SRC_IN,
		SRC_K12,
		SRC_K01,
		SRC_RES,
		SRC_ZERO
	} src_t;

	typedef enum logic [1:0] {
		JOB_BLOCK,
		JOB_K1,
		JOB_K0,
		JOB_FILL
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COPY,
		ST_START,
		ST_AB,
		ST_CD,
		ST_FIN,
		ST_END,
		ST_XORP,
		ST_WR0,
		ST_WR1
	} state_t;

	typedef struct packed {
		logic        src_wr;
		logic        seed;
		logic        copy_rd;
		logic        start;
		src_t        src;
		logic        dec;
		logic        rd_ab;
		logic        rd_cd;
		logic        fin;
		logic [4:0]  pk;
		logic        xorp;
		logic        kw_ld12;
		logic        kw_ld01;
		logic        shift;
		logic        s_ld;
		logic        wr0;
		logic        wr1;
		logic [10:0] idx;
	} bfk_cmd_t;

endpackage

// ===== hdl/bfk_if.sv =====
// request and result channels
interface bfk_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [10:0] word_index;
	logic [31:0] table_word;
	logic [31:0] block_word0;
	logic [31:0] block_word1;
	modport source (output valid, action, word_index, table_word, block_word0, block_word1,
		input ready);
	modport sink (input valid, action, word_index, table_word, block_word0, block_word1,
		output ready);
endinterface

interface bfk_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_word0;
	logic [31:0] out_word1;
	modport source (output valid, out_word0, out_word1, input ready);
	modport sink (input valid, out_word0, out_word1, output ready);
endinterface

// ===== hdl/blowfish_block_cipher_keyed_top.sv =====
// top level of the keyed blowfish-style block cipher
//
// channel  | dir | payload                                               | meaning
// item     | in  | action, word_index, table_word, block_word0/1         | one request
// result   | out | out_word0, out_word1                                  | cipher output
// cfg      | in  | cfg_we, cfg_idx, cfg_data                             | register writes
//
// load: written straight into the source table. encrypt/decrypt: per round, two s-box reads a cycle on
// the two-port working table, then the round add/xor, plus start and finish.
// schedule: a copy sweep of the source table, then per mixing pass two key-word encryptions,
// the p-array key xor, and 521 chained block encryptions with two table writes each.
// reset clears control and configuration registers only; tables hold nothing until written.
// a finished result sits in the output register while the next request is taken;
// a new result waits for the old one to leave.
module blowfish_block_cipher_keyed_top import bfk_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	bfk_item_if.sink     item,
	bfk_result_if.source result,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [31:0]  cfg_data
);

	// configuration registers
	logic [31:0] id_code_q;
	logic [1:0]  key_level_q;
	logic [3:0]  key_modulo_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out0_q, out1_q;

	logic        out_busy, out_load;
	bfk_cmd_t    cmd;
	logic [31:0] res0, res1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_code_q    <= '0;
			key_level_q  <= 2'd1;
			key_modulo_q <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ID_CODE:    id_code_q    <= cfg_data;
				CFG_KEY_LEVEL:  key_level_q  <= cfg_data[1:0];
				CFG_KEY_MODULO: key_modulo_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// result holds until taken
	assign out_busy = out_valid_q & ~result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out0_q <= res0;
			out1_q <= res1;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_word0 = out0_q;
	assign result.out_word1 = out1_q;

	bfk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.action    (action_t'(item.action)),
		.key_level (key_level_q),
		.out_busy  (out_busy),
		.in_ready  (item.ready),
		.out_load  (out_load),
		.cmd       (cmd)
	);

	bfk_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.id_code     (id_code_q),
		.key_modulo  (key_modulo_q),
		.word_index  (item.word_index),
		.table_word  (item.table_word),
		.block_word0 (item.block_word0),
		.block_word1 (item.block_word1),
		.res0        (res0),
		.res1        (res1)
	);

endmodule

// ===== hdl/bfk_datapath.sv =====
// tables, key words and round datapath
module bfk_datapath import bfk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bfk_cmd_t    cmd,
	input  logic [31:0] id_code,
	input  logic [3:0]  key_modulo,
	input  logic [10:0] word_index,
	input  logic [31:0] table_word,
	input  logic [31:0] block_word0,
	input  logic [31:0] block_word1,
	output logic [31:0] res0,
	output logic [31:0] res1
);

	logic [31:0] src_mem [TABLE_WORDS];
	logic [31:0] key_mem [SBOX_WORDS];
	logic [31:0] p_q [P_WORDS];
	logic [31:0] kw_q [3];
	logic [31:0] y_q, z_q, sum_q, rd0_q, rd1_q, s0_q, s1_q;
	logic        dec_q;
	logic [4:0]  boff_q;
	logic [31:0] cp_data_s1;
	logic [10:0] cp_idx_s1;
	logic        cp_vld_s1;

	logic        dec_sel;
	logic [4:0]  p_addr;
	logic [31:0] p_rd;
	logic [31:0] w0, w1, f, xn;
	logic [9:0]  ra0, ra1;
	logic        kwe;
	logic [10:0] kidx;
	logic [9:0]  kaddr;
	logic [31:0] kdata;
	logic [10:0] widx;
	logic [31:0] wdata;
	logic [4:0]  m, b, bn;
	logic [31:0] kx;

	function automatic logic [31:0] swap_bytes(logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic logic [4:0] p_index(logic dec, logic [4:0] k);
		return dec ? (5'(P_LAST) - k) : k;
	endfunction

	assign dec_sel = cmd.start ? cmd.dec : dec_q;
	assign p_addr  = cmd.xorp ? cmd.idx[4:0] : p_index(dec_sel, cmd.pk);
	assign p_rd    = p_q[p_addr];

	always_comb begin
		case (cmd.src)
			SRC_IN: begin
				w0 = block_word0;
				w1 = block_word1;
			end
			SRC_K12: begin
				w0 = kw_q[1];
				w1 = kw_q[2];
			end
			SRC_K01: begin
				w0 = kw_q[0];
				w1 = kw_q[1];
			end
			SRC_RES: begin
				w0 = s0_q;
				w1 = s1_q;
			end
			default: begin
				w0 = '0;
				w1 = '0;
			end
		endcase
	end

	assign f    = (sum_q ^ rd0_q) + rd1_q;
	assign xn   = y_q ^ f;
	assign res0 = z_q;
	assign res1 = y_q ^ p_rd;

	// round registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			y_q   <= w0;
			z_q   <= p_rd ^ w1;
			dec_q <= cmd.dec;
		end else if (cmd.fin) begin
			y_q <= z_q;
			z_q <= p_rd ^ xn;
		end
		if (cmd.rd_cd)
			sum_q <= rd0_q + rd1_q;
		if (cmd.s_ld) begin
			s0_q <= res0;
			s1_q <= res1;
		end
	end

	// s-box reads, two ports
	always_comb begin
		if (cmd.rd_cd) begin
			ra0 = {2'd2, z_q[15:8]};
			ra1 = {2'd3, z_q[7:0]};
		end else begin
			ra0 = {2'd0, z_q[31:24]};
			ra1 = {2'd1, z_q[23:16]};
		end
	end

	always_ff @(posedge clk) begin
		rd0_q <= key_mem[ra0];
		rd1_q <= key_mem[ra1];
	end

	// working table writes: copy or fill
	assign widx  = cmd.wr1 ? cmd.idx : cmd.idx;
	assign wdata = cmd.wr0 ? s1_q : s0_q;

	always_comb begin
		if (cp_vld_s1) begin
			kidx  = cp_idx_s1;
			kdata = cp_data_s1;
			kwe   = 1'b1;
		end else begin
			kidx  = widx;
			kdata = wdata;
			kwe   = cmd.wr0 | cmd.wr1;
		end
	end

	assign kaddr = 10'(kidx - P_BASE);

	always_ff @(posedge clk) begin
		if (kwe && kidx >= P_BASE)
			key_mem[kaddr] <= kdata;
	end

	// byte offset modulo for the p-array key mix
	assign m = (key_modulo == 4'd0) ? 5'd16 : {1'b0, key_modulo};
	assign b = (cmd.idx == 11'd0) ? 5'd0 : boff_q;
	assign kx = (b[3:2] == 2'd3) ? 32'd0 : kw_q[b[3:2]];

	always_comb begin
		bn = b + 5'd4;
		for (int i = 0; i < 4; i++) begin
			if (bn >= m)
				bn = bn - m;
		end
	end

	always_ff @(posedge clk) begin
		if (kwe && kidx < P_BASE)
			p_q[kidx[4:0]] <= kdata;
		else if (cmd.xorp)
			p_q[p_addr] <= p_rd ^ swap_bytes(kx);
		if (cmd.xorp)
			boff_q <= bn;
	end

	// key words
	always_ff @(posedge clk) begin
		if (cmd.seed) begin
			kw_q[0] <= id_code;
			kw_q[1] <= id_code >> 1;
			kw_q[2] <= id_code << 1;
		end else if (cmd.kw_ld12) begin
			kw_q[1] <= res0;
			kw_q[2] <= res1;
		end else if (cmd.kw_ld01) begin
			kw_q[0] <= res0;
			kw_q[1] <= res1;
		end else if (cmd.shift) begin
			kw_q[1] <= kw_q[1] << 1;
			kw_q[2] <= kw_q[2] >> 1;
		end
	end

	// source table
	always_ff @(posedge clk) begin
		if (cmd.src_wr && word_index < TABLE_END)
			src_mem[word_index] <= table_word;
		if (cmd.copy_rd) begin
			cp_data_s1 <= src_mem[cmd.idx];
			cp_idx_s1  <= cmd.idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cp_vld_s1 <= 1'b0;
		else
			cp_vld_s1 <= cmd.copy_rd;
	end

endmodule

// ===== hdl/bfk_ctrl.sv =====
// controller state machine
module bfk_ctrl import bfk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  action_t    action,
	input  logic [1:0] key_level,
	input  logic       out_busy,
	output logic       in_ready,
	output logic       out_load,
	output bfk_cmd_t   cmd
);

	state_t      state_q, state_d;
	logic [10:0] cnt_q, cnt_d;
	logic [3:0]  rnd_q, rnd_d;
	job_t        job_q, job_d;
	src_t        src_q, src_d;
	logic [1:0]  pass_q, pass_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rnd_q   <= '0;
			job_q   <= JOB_BLOCK;
			src_q   <= SRC_IN;
			pass_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rnd_q   <= rnd_d;
			job_q   <= job_d;
			src_q   <= src_d;
			pass_q  <= pass_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		rnd_d    = rnd_q;
		job_d    = job_q;
		src_d    = src_q;
		pass_d   = pass_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (action)
						ACT_LOAD: cmd.src_wr = 1'b1;
						ACT_SCHED: begin
							cmd.seed = 1'b1;
							cnt_d    = '0;
							state_d  = ST_COPY;
						end
						default: begin
							cmd.start = 1'b1;
							cmd.src   = SRC_IN;
							cmd.dec   = (action == ACT_DEC);
							rnd_d     = '0;
							job_d     = JOB_BLOCK;
							state_d   = ST_AB;
						end
					endcase
				end
			end
			ST_COPY: begin
				if (cnt_q != TABLE_END) begin
					cmd.copy_rd = 1'b1;
					cmd.idx     = cnt_q;
					cnt_d       = cnt_q + 11'd1;
				end else begin
					pass_d = '0;
					if (key_level == 2'd0) begin
						state_d = ST_IDLE;
					end else begin
						job_d   = JOB_K1;
						src_d   = SRC_K12;
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				cmd.src   = src_q;
				rnd_d     = '0;
				state_d   = ST_AB;
			end
			ST_AB: begin
				cmd.rd_ab = 1'b1;
				state_d   = ST_CD;
			end
			ST_CD: begin
				cmd.rd_cd = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				cmd.pk  = {1'b0, rnd_q} + 5'd1;
				if (rnd_q == 4'(ROUNDS - 1)) begin
					state_d = ST_END;
				end else begin
					rnd_d   = rnd_q + 4'd1;
					state_d = ST_AB;
				end
			end
			ST_END: begin
				cmd.pk = 5'(P_LAST);
				case (job_q)
					JOB_BLOCK: begin
						if (!out_busy) begin
							out_load = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					JOB_K1: begin
						cmd.kw_ld12 = 1'b1;
						job_d       = JOB_K0;
						src_d       = SRC_K01;
						state_d     = ST_START;
					end
					JOB_K0: begin
						cmd.kw_ld01 = 1'b1;
						cnt_d       = '0;
						state_d     = ST_XORP;
					end
					default: begin
						cmd.s_ld = 1'b1;
						state_d  = ST_WR0;
					end
				endcase
			end
			ST_XORP: begin
				cmd.xorp = 1'b1;
				cmd.idx  = cnt_q;
				if (cnt_q == P_LAST) begin
					cnt_d   = '0;
					job_d   = JOB_FILL;
					src_d   = SRC_ZERO;
					state_d = ST_START;
				end else begin
					cnt_d = cnt_q + 11'd1;
				end
			end
			ST_WR0: begin
				cmd.wr0 = 1'b1;
				cmd.idx = cnt_q;
				state_d = ST_WR1;
			end
			ST_WR1: begin
				cmd.wr1 = 1'b1;
				cmd.idx = cnt_q + 11'd1;
				if (cnt_q == FILL_LAST) begin
					if ({1'b0, pass_q} + 3'd1 < {1'b0, key_level}) begin
						pass_d    = pass_q + 2'd1;
						cmd.shift = (pass_q == 2'd1);
						job_d     = JOB_K1;
						src_d     = SRC_K12;
						state_d   = ST_START;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					cnt_d   = cnt_q + 11'd2;
					src_d   = SRC_RES;
					state_d = ST_START;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hdl/bfk_checker.sv =====
// port-level checks on the cipher top, bound to it
module bfk_checker import bfk_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic [1:0]  item_action,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_word0,
	input logic [31:0] res_word1
);

	// stalled result keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_word0) && $stable(res_word1))
		else $error("result changed while stalled");

	// a cipher request keeps the block busy
	a_cipher_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_action == ACT_ENC || item_action == ACT_DEC)
		|=> !item_ready)
		else $error("request taken during cipher work");

	// a load completes at once
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_action == ACT_LOAD |=> item_ready)
		else $error("load stalled the block");

	// a new result comes only out of busy work
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!item_ready))
		else $error("result without cipher work");

endmodule

bind blowfish_block_cipher_keyed_top bfk_checker u_bfk_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.item_action (item.action),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_word0   (result.out_word0),
	.res_word1   (result.out_word1)
);

// ===== tb/sv/bfk_cipher_checker.sv =====
`timescale 1ns / 100ps
// watches the channels of the keyed block cipher, predicts each result and compares it
module bfk_cipher_checker import bfk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	bfk_item_if         item,
	bfk_result_if       result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic [31:0] w0;
		logic [31:0] w1;
	} block_t;

	logic [31:0] src_tab [TABLE_WORDS];
	logic [31:0] key_tab [TABLE_WORDS];
	logic [31:0] key_wd [3];
	logic [31:0] id_code    = '0;
	logic [1:0]  key_level  = 2'd1;
	logic [3:0]  key_modulo = 4'd8;
	block_t      block_q[$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic logic [31:0] sbox_mix(input logic [31:0] z);
		logic [31:0] r;
		r = key_tab[18 + z[31:24]];
		r = r + key_tab[274 + z[23:16]];
		r = r ^ key_tab[530 + z[15:8]];
		r = r + key_tab[786 + z[7:0]];
		return r;
	endfunction

	// sixteen rounds; decryption walks the p array from the top
	function automatic void crypt_block(input bit dec, inout logic [31:0] a, inout logic [31:0] b);
		logic [31:0] y, x, z;
		y = a;
		x = b;
		for (int r = 0; r < ROUNDS; r++) begin
			z = key_tab[dec ? 17 - r : r] ^ x;
			x = y ^ sbox_mix(z);
			y = z;
		end
		if (dec) begin
			a = x ^ key_tab[1];
			b = y ^ key_tab[0];
		end else begin
			a = x ^ key_tab[16];
			b = y ^ key_tab[17];
		end
	endfunction

	function automatic void mix_keys();
		int unsigned m, sel;
		logic [31:0] k, s0, s1;
		m  = (key_modulo == 0) ? 16 : key_modulo;
		s0 = '0;
		s1 = '0;
		crypt_block(1'b0, key_wd[1], key_wd[2]);
		crypt_block(1'b0, key_wd[0], key_wd[1]);
		for (int i = 0; i < P_WORDS; i++) begin
			sel = ((i * 4) % m) >> 2;
			k   = (sel < 3) ? key_wd[sel] : '0;
			key_tab[i] ^= {k[7:0], k[15:8], k[23:16], k[31:24]};
		end
		for (int i = 0; i + 1 < TABLE_WORDS; i += 2) begin
			crypt_block(1'b0, s0, s1);
			key_tab[i]     = s1;
			key_tab[i + 1] = s0;
		end
	endfunction

	function automatic void run_schedule();
		key_tab   = src_tab;
		key_wd[0] = id_code;
		key_wd[1] = id_code >> 1;
		key_wd[2] = id_code << 1;
		if (key_level >= 1) mix_keys();
		if (key_level >= 2) mix_keys();
		key_wd[1] = key_wd[1] << 1;
		key_wd[2] = key_wd[2] >> 1;
		if (key_level >= 3) mix_keys();
	endfunction

	always @(posedge clk) begin
		block_t exp_blk, got;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_idx))
					CFG_ID_CODE:    id_code    = cfg_data;
					CFG_KEY_LEVEL:  key_level  = cfg_data[1:0];
					CFG_KEY_MODULO: key_modulo = cfg_data[3:0];
					default: ;
				endcase
			end
			// results first, so a result is never matched to a request of the same edge
			if (result.valid && result.ready) begin
				if (block_q.size() == 0) begin
					$display("%0t: unexpected result %h %h", $time, result.out_word0,
						result.out_word1);
					fail_count++;
				end else begin
					exp_blk = block_q.pop_front();
					if (result.out_word0 !== exp_blk.w0) begin
						$display("%0t: out_word0 expected %h actual %h", $time, exp_blk.w0,
							result.out_word0);
						fail_count++;
					end
					if (result.out_word1 !== exp_blk.w1) begin
						$display("%0t: out_word1 expected %h actual %h", $time, exp_blk.w1,
							result.out_word1);
						fail_count++;
					end
				end
			end
			if (item.valid && item.ready) begin
				got.w0 = item.block_word0;
				got.w1 = item.block_word1;
				case (action_t'(item.action))
					ACT_LOAD:  if (item.word_index < TABLE_END) src_tab[item.word_index] = item.table_word;
					ACT_SCHED: run_schedule();
					ACT_ENC: begin
						crypt_block(1'b0, got.w0, got.w1);
						block_q.push_back(got);
					end
					default: begin
						crypt_block(1'b1, got.w0, got.w1);
						block_q.push_back(got);
					end
				endcase
			end
			pending = block_q.size();
		end
	end

endmodule

// ===== tb/sv/blowfish_block_cipher_keyed_top_tb.sv =====
`timescale 1ns / 100ps
// stimulus, receiver and verdict for the keyed block cipher
module blowfish_block_cipher_keyed_top_tb;
	import bfk_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int HOLD_CYCLES = 600;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx  = '0;
	logic [31:0] cfg_data = '0;
	int          fail_count, pending;
	int          cycles    = 0;
	int          idle_mode = 0;   // 0 none, 1 sender gaps, 2 receiver stalls, 3 light both
	bit          hold_req  = 1'b0;
	int          hold_left = 0;

	bfk_item_if   item();
	bfk_result_if result();

	// key settings per phase: extremes, modulo zero and modulo above twelve among them
	logic [31:0] ph_id  [6];
	logic [1:0]  ph_lvl [6] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd1};
	logic [3:0]  ph_mod [6] = '{4'd1, 4'd12, 4'd0, 4'd15, 4'd5, 4'd8};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	blowfish_block_cipher_keyed_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item.sink),
		.result   (result.source),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	bfk_cipher_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stalls by phase, or one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left     <= HOLD_CYCLES;
			hold_req      <= 1'b0;
			result.ready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			result.ready <= 1'b0;
		end else begin
			case (idle_mode)
				2:       result.ready <= ($urandom_range(99) >= 84);
				3:       result.ready <= ($urandom_range(99) >= 10);
				default: result.ready <= 1'b1;
			endcase
		end
	end

	// offer one request, after a random gap in idle modes 1 and 3; returns at the edge that takes it
	task automatic send(input action_t act, input logic [10:0] ix, input logic [31:0] tw,
		input logic [31:0] w0, input logic [31:0] w1);
		int gap;
		gap = 0;
		if (idle_mode == 1)
			while ($urandom_range(99) < 84) gap++;
		else if (idle_mode == 3)
			while ($urandom_range(99) < 10) gap++;
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid       <= 1'b1;
		item.action      <= act;
		item.word_index  <= ix;
		item.table_word  <= tw;
		item.block_word0 <= w0;
		item.block_word1 <= w1;
		@(negedge clk);
		while (!item.ready) @(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [31:0] any_word();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// mostly cipher requests, with some table loads, a few out of range
	task automatic random_request();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			send(ACT_LOAD, ($urandom_range(4) == 0) ? 11'($urandom_range(1042, 2047))
				: 11'($urandom_range(1041)), any_word(), $urandom, $urandom);
		else
			send((r < 54) ? ACT_ENC : ACT_DEC, 11'($urandom), $urandom, any_word(), any_word());
	endtask

	// stop offering until every result is back and the block has gone quiet
	task automatic drain();
		item.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_keys(input logic [31:0] id, input logic [1:0] lvl, input logic [3:0] md);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_ID_CODE;
		cfg_data <= id;
		@(posedge clk);
		cfg_idx  <= CFG_KEY_LEVEL;
		cfg_data <= 32'(lvl);
		@(posedge clk);
		cfg_idx  <= CFG_KEY_MODULO;
		cfg_data <= 32'(md);
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	initial begin
		item.valid       = 1'b0;
		item.action      = ACT_LOAD;
		item.word_index  = '0;
		item.table_word  = '0;
		item.block_word0 = '0;
		item.block_word1 = '0;
		result.ready     = 1'b0;
		ph_id[0] = '0;
		ph_id[1] = '1;
		for (int i = 2; i < 6; i++) ph_id[i] = $urandom;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole source table before any schedule reads it
		for (int i = 0; i < TABLE_WORDS; i++)
			send(ACT_LOAD, 11'(i), (i == 0) ? '0 : (i == 1) ? '1 : $urandom,
				$urandom, $urandom);

		// directed: ignored loads, a load of the last word, schedule at reset settings, extreme blocks
		send(ACT_LOAD, TABLE_END, '1, '1, '1);
		send(ACT_LOAD, 11'h7ff, '1, '0, '0);
		send(ACT_LOAD, TABLE_LAST, '1, '0, '1);
		send(ACT_SCHED, '0, '0, '0, '0);
		send(ACT_ENC, '0, '0, '0, '0);
		send(ACT_ENC, '1, '1, '1, '1);
		send(ACT_DEC, '0, '0, '0, '0);
		send(ACT_DEC, '1, '1, '1, '1);
		send(ACT_ENC, '0, '0, '0, '1);
		send(ACT_DEC, '0, '0, '1, '0);

		for (int p = 0; p < 6; p++) begin
			drain();
			write_keys(ph_id[p], ph_lvl[p], ph_mod[p]);
			idle_mode = 0;
			send(ACT_SCHED, 11'($urandom), $urandom, $urandom, $urandom);
			// a stretch with no idling, then the phase's own idling
			for (int n = 0; n < 100; n++) begin
				if (n == 20) idle_mode = p % 4;
				random_request();
			end
			if (p == 1) begin
				// long receiver hold-off with requests still offered back to back
				idle_mode = 0;
				hold_req  = 1'b1;
				repeat (30) send(ACT_ENC, '0, '0, $urandom, $urandom);
				drain();
				idle_mode = 3;
			end
			// a result that can only come after the schedule is done
			send(ACT_ENC, '0, '0, $urandom, $urandom);
		end

		drain();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== blowfish_block_cipher_keyed_top.f =====
hdl/bfk_pkg.sv
hdl/bfk_if.sv
hdl/bfk_datapath.sv
hdl/bfk_ctrl.sv
hdl/blowfish_block_cipher_keyed_top.sv
hdl/bfk_checker.sv
tb/sv/bfk_cipher_checker.sv
tb/sv/blowfish_block_cipher_keyed_top_tb.sv
